/* src/aabbct_pkg.sv */
// Shared types, widths and codes for the box collision tester.
package aabbct_pkg;

  localparam int unsigned CoordWidth    = 32;
  localparam int unsigned HalfWidth     = CoordWidth - 1;
  localparam int unsigned BoundWidth    = CoordWidth + 1;
  localparam int unsigned DiffWidth     = CoordWidth + 2;
  localparam int unsigned SquareWidth   = 2 * CoordWidth;
  localparam int unsigned RegIndexWidth = 3;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic [HalfWidth-1:0]         ucoord_t;
  typedef logic signed [BoundWidth-1:0] bound_t;
  typedef logic [1:0]                   cmd_t;
  typedef logic [RegIndexWidth-1:0]     reg_index_t;

  localparam cmd_t CMD_BOX    = 2'd0;
  localparam cmd_t CMD_SPHERE = 2'd1;
  localparam cmd_t CMD_POINT  = 2'd2;

  localparam reg_index_t REG_CENTER_X = 3'd0;
  localparam reg_index_t REG_CENTER_Y = 3'd1;
  localparam reg_index_t REG_CENTER_Z = 3'd2;
  localparam reg_index_t REG_HALF_X   = 3'd3;
  localparam reg_index_t REG_HALF_Y   = 3'd4;
  localparam reg_index_t REG_HALF_Z   = 3'd5;

  localparam ucoord_t HALF_RESET = HalfWidth'(32768);
  localparam coord_t  PEN_MAX    = {1'b0, {(CoordWidth-1){1'b1}}};
  localparam coord_t  PEN_MIN    = {1'b1, {(CoordWidth-1){1'b0}}};

  typedef struct packed {
    cmd_t    cmd;
    coord_t  a_x;
    coord_t  a_y;
    coord_t  a_z;
    coord_t  b_x;
    coord_t  b_y;
    coord_t  b_z;
    ucoord_t radius;
  } query_t;

  typedef struct packed {
    logic   hit;
    coord_t pen_x;
    coord_t pen_y;
    coord_t pen_z;
  } result_t;

  typedef struct packed {
    bound_t [2:0] lo;
    bound_t [2:0] hi;
    bound_t [2:0] c2;
  } box_t;

endpackage

/* src/aabb_collision_tester.sv */
// Top level: five-stage pipeline testing queries against the configured box.
//
//  Channel  | Signals                               | Direction | Contents
//  query    | query_valid, query_ready, query       | in        | command, coords, radius
//  result   | result_valid, result_ready, result    | out       | hit, penetration vector
//  cfg      | cfg_valid, cfg_ready, cfg_index/data  | in        | register index and value
//
// A transaction passes stage registers s1 to s4 and then the result register. A new
// one can be accepted every cycle while query_ready holds; the sphere squarers set the depth.
// Synchronous reset empties the pipeline and restores the default box.
// A result stall holds each occupied stage whose successor is held; empty stages keep filling.
module aabb_collision_tester (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   query_valid,
  output logic                   query_ready,
  input  aabbct_pkg::query_t     query,
  output logic                   result_valid,
  input  logic                   result_ready,
  output aabbct_pkg::result_t    result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  aabbct_pkg::reg_index_t cfg_index,
  input  aabbct_pkg::coord_t     cfg_data
);
  import aabbct_pkg::*;

  box_t box;
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4, en5;

  coord_t qa [3];
  coord_t qb [3];
  logic signed [DiffWidth-1:0]  p1 [3];
  logic signed [DiffWidth-1:0]  q1 [3];
  logic signed [DiffWidth-1:0]  m1 [3];
  logic signed [BoundWidth-1:0] sab1 [3];

  logic signed [DiffWidth-1:0]  s1_p [3];
  logic signed [DiffWidth-1:0]  s1_q [3];
  logic signed [DiffWidth-1:0]  s1_m [3];
  logic signed [BoundWidth-1:0] s1_sab [3];
  cmd_t    s1_cmd;
  ucoord_t s1_radius;

  logic [2:0] ok2;
  logic [2:0] below2;
  logic [2:0] in2;
  logic signed [DiffWidth-1:0] pneg2 [3];
  logic signed [DiffWidth-1:0] ov2 [3];
  logic [CoordWidth-1:0] d2 [3];

  logic signed [DiffWidth-1:0] s2_ov [3];
  logic [2:0] s2_ok;
  logic [2:0] s2_below;
  logic [2:0] s2_in;
  logic [CoordWidth-1:0] s2_d [3];
  cmd_t    s2_cmd;
  ucoord_t s2_radius;

  logic sel0, sel1;
  logic [2:0] axis3;
  logic signed [DiffWidth-1:0] ov3;
  logic below3;

  logic signed [DiffWidth-1:0] s3_ov;
  logic [2:0] s3_axis;
  logic s3_below;
  logic s3_boxhit;
  logic s3_pointhit;
  cmd_t s3_cmd;

  logic signed [DiffWidth-1:0] negov4;
  logic signed [DiffWidth-1:0] val4;
  logic fits4;
  coord_t sat4;
  coord_t pen4 [3];

  coord_t s4_pen [3];
  logic s4_boxhit;
  logic s4_pointhit;
  cmd_t s4_cmd;

  logic [SquareWidth-1:0] dsq [3];
  logic [SquareWidth-1:0] rsq;
  logic [SquareWidth+1:0] dsum5;
  logic sph5;
  logic hit5;

  assign cfg_ready = 1'b1;

  aabbct_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg_valid & cfg_ready),
    .index (cfg_index),
    .data  (cfg_data),
    .box   (box)
  );

  // Stage flow control: a stage moves on when it is empty or its successor moves.
  assign en5 = !result_valid || result_ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign query_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (en1) v1 <= query_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) result_valid <= v4;
    end
  end

  // Stage 1: distances from the query to the box bounds, and the sum of the two corners.
  always_comb begin
    qa[0] = query.a_x;
    qa[1] = query.a_y;
    qa[2] = query.a_z;
    qb[0] = query.b_x;
    qb[1] = query.b_y;
    qb[2] = query.b_z;
    for (int i = 0; i < 3; i++) begin
      p1[i] = {box.hi[i][BoundWidth-1], box.hi[i]} - {{2{qa[i][CoordWidth-1]}}, qa[i]};
      q1[i] = {{2{qb[i][CoordWidth-1]}}, qb[i]} - {box.lo[i][BoundWidth-1], box.lo[i]};
      m1[i] = {box.lo[i][BoundWidth-1], box.lo[i]} - {{2{qa[i][CoordWidth-1]}}, qa[i]};
      sab1[i] = {qa[i][CoordWidth-1], qa[i]} + {qb[i][CoordWidth-1], qb[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int i = 0; i < 3; i++) begin
        s1_p[i]   <= p1[i];
        s1_q[i]   <= q1[i];
        s1_m[i]   <= m1[i];
        s1_sab[i] <= sab1[i];
      end
      s1_cmd    <= query.cmd;
      s1_radius <= query.radius;
    end
  end

  // Stage 2: per-axis overlap, containment, center order and clamp distance.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ok2[i]    = !s1_p[i][DiffWidth-1] && !s1_q[i][DiffWidth-1];
      below2[i] = $signed(box.c2[i]) < s1_sab[i];
      in2[i]    = (s1_m[i][DiffWidth-1] || (s1_m[i] == '0)) && !s1_p[i][DiffWidth-1];
      pneg2[i]  = -s1_p[i];
      ov2[i]    = (s1_p[i] < s1_q[i]) ? s1_p[i] : s1_q[i];
      if (!s1_m[i][DiffWidth-1] && (s1_m[i] != '0)) begin
        d2[i] = s1_m[i][CoordWidth-1:0];
      end else if (s1_p[i][DiffWidth-1]) begin
        d2[i] = pneg2[i][CoordWidth-1:0];
      end else begin
        d2[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      for (int i = 0; i < 3; i++) begin
        s2_ov[i] <= ov2[i];
        s2_d[i]  <= d2[i];
      end
      s2_ok     <= ok2;
      s2_below  <= below2;
      s2_in     <= in2;
      s2_cmd    <= s1_cmd;
      s2_radius <= s1_radius;
    end
  end

  // Stages 3 and 4 of the sphere test live in the squarers.
  for (genvar g = 0; g < 3; g++) begin : g_dsq
    aabbct_sq u_sq (
      .clk    (clk),
      .en_pp  (en3),
      .en_sum (en4),
      .d      (s2_d[g]),
      .sq     (dsq[g])
    );
  end

  aabbct_sq u_rsq (
    .clk    (clk),
    .en_pp  (en3),
    .en_sum (en4),
    .d      ({1'b0, s2_radius}),
    .sq     (rsq)
  );

  // Stage 3: axis of least overlap, ties going to x and then y.
  always_comb begin
    sel0 = (s2_ov[0] <= s2_ov[1]) && (s2_ov[0] <= s2_ov[2]);
    sel1 = s2_ov[1] <= s2_ov[2];
    if (sel0) begin
      axis3  = 3'b001;
      ov3    = s2_ov[0];
      below3 = s2_below[0];
    end else if (sel1) begin
      axis3  = 3'b010;
      ov3    = s2_ov[1];
      below3 = s2_below[1];
    end else begin
      axis3  = 3'b100;
      ov3    = s2_ov[2];
      below3 = s2_below[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_ov       <= ov3;
      s3_axis     <= axis3;
      s3_below    <= below3;
      s3_boxhit   <= &s2_ok;
      s3_pointhit <= &s2_in;
      s3_cmd      <= s2_cmd;
    end
  end

  // Stage 4: signed, saturated penetration on the chosen axis.
  always_comb begin
    negov4 = -s3_ov;
    val4   = s3_below ? negov4 : s3_ov;
    fits4  = (&val4[DiffWidth-1:CoordWidth-1]) || !(|val4[DiffWidth-1:CoordWidth-1]);
    if (fits4) begin
      sat4 = val4[CoordWidth-1:0];
    end else if (val4[DiffWidth-1]) begin
      sat4 = PEN_MIN;
    end else begin
      sat4 = PEN_MAX;
    end
    for (int i = 0; i < 3; i++) begin
      pen4[i] = ((s3_cmd == CMD_BOX) && s3_boxhit && s3_axis[i]) ? sat4 : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      for (int i = 0; i < 3; i++) begin
        s4_pen[i] <= pen4[i];
      end
      s4_boxhit   <= s3_boxhit;
      s4_pointhit <= s3_pointhit;
      s4_cmd      <= s3_cmd;
    end
  end

  // Stage 5: squared distance against squared radius, then the result register.
  always_comb begin
    dsum5 = {2'b00, dsq[0]} + {2'b00, dsq[1]} + {2'b00, dsq[2]};
    sph5  = dsum5 <= {2'b00, rsq};
    case (s4_cmd)
      CMD_BOX:    hit5 = s4_boxhit;
      CMD_SPHERE: hit5 = sph5;
      CMD_POINT:  hit5 = s4_pointhit;
      default:    hit5 = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      result.hit   <= hit5;
      result.pen_x <= s4_pen[0];
      result.pen_y <= s4_pen[1];
      result.pen_z <= s4_pen[2];
    end
  end

endmodule

/* src/aabbct_cfg.sv */
// Configuration registers and the derived box bounds.
module aabbct_cfg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  aabbct_pkg::reg_index_t index,
  input  aabbct_pkg::coord_t     data,
  output aabbct_pkg::box_t       box
);
  import aabbct_pkg::*;

  coord_t  center [3];
  ucoord_t half [3];
  logic [2:0] wr_center;
  logic [2:0] wr_half;
  ucoord_t hdata;

  assign hdata = data[HalfWidth-1:0];

  always_comb begin
    wr_center = '0;
    wr_half   = '0;
    if (wr_en) begin
      case (index)
        REG_CENTER_X: wr_center = 3'b001;
        REG_CENTER_Y: wr_center = 3'b010;
        REG_CENTER_Z: wr_center = 3'b100;
        REG_HALF_X:   wr_half   = 3'b001;
        REG_HALF_Y:   wr_half   = 3'b010;
        REG_HALF_Z:   wr_half   = 3'b100;
        default: begin
        end
      endcase
    end
  end

  // The bounds are updated together with the register written, so they are
  // valid at the very next edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        center[i] <= '0;
        half[i]   <= HALF_RESET;
        box.lo[i] <= -$signed({2'b00, HALF_RESET});
        box.hi[i] <= {2'b00, HALF_RESET};
        box.c2[i] <= '0;
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (wr_center[i]) begin
          center[i] <= data;
          box.lo[i] <= {data[CoordWidth-1], data} - {2'b00, half[i]};
          box.hi[i] <= {data[CoordWidth-1], data} + {2'b00, half[i]};
          box.c2[i] <= {data, 1'b0};
        end else if (wr_half[i]) begin
          half[i]   <= hdata;
          box.lo[i] <= {center[i][CoordWidth-1], center[i]} - {2'b00, hdata};
          box.hi[i] <= {center[i][CoordWidth-1], center[i]} + {2'b00, hdata};
        end
      end
    end
  end

endmodule

/* src/aabbct_sq.sv */
// Two-stage squarer built from half-width partial products.
module aabbct_sq (
  input  logic                                clk,
  input  logic                                en_pp,
  input  logic                                en_sum,
  input  logic [aabbct_pkg::CoordWidth-1:0]   d,
  output logic [aabbct_pkg::SquareWidth-1:0]  sq
);
  import aabbct_pkg::*;

  localparam int unsigned LoWidth = (CoordWidth + 1) / 2;
  localparam int unsigned HiWidth = CoordWidth - LoWidth;

  logic [2*HiWidth-1:0] pp_hh;
  logic [CoordWidth-1:0] pp_hl;
  logic [2*LoWidth-1:0] pp_ll;

  always_ff @(posedge clk) begin
    if (en_pp) begin
      pp_hh <= d[CoordWidth-1:LoWidth] * d[CoordWidth-1:LoWidth];
      pp_hl <= d[CoordWidth-1:LoWidth] * d[LoWidth-1:0];
      pp_ll <= d[LoWidth-1:0] * d[LoWidth-1:0];
    end
    if (en_sum) begin
      sq <= {pp_hh, {(2*LoWidth){1'b0}}}
          + {{(HiWidth-1){1'b0}}, pp_hl, {(LoWidth+1){1'b0}}}
          + {{(2*HiWidth){1'b0}}, pp_ll};
    end
  end

endmodule

/* src/aabbct_chk.sv */
// Port-level checker for the box collision tester, bound to the top level.
module aabbct_chk (
  input logic                   clk,
  input logic                   rst,
  input logic                   result_valid,
  input logic                   result_ready,
  input aabbct_pkg::result_t    result,
  input logic                   cfg_valid,
  input logic                   cfg_ready
);
  import aabbct_pkg::*;

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("Stalled result transaction was dropped or changed.");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("Result valid right after reset.");

  a_pen_needs_hit: assert property (@(posedge clk) disable iff (rst)
    result_valid && ((result.pen_x != '0) || (result.pen_y != '0) || (result.pen_z != '0))
    |-> result.hit)
    else $error("Penetration reported without a hit.");

  a_pen_one_axis: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
    $onehot0({result.pen_x != '0, result.pen_y != '0, result.pen_z != '0}))
    else $error("Penetration reported on more than one axis.");

  a_cfg_always_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("Configuration transaction refused.");

endmodule

bind aabb_collision_tester aabbct_chk u_aabbct_chk (.*);

/* tb/sv/aabb_collision_checker.sv */
// Checker for the box collision tester: predicts each result and compares it.
module aabb_collision_checker
  import aabbct_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        query_valid,
  input  logic        query_ready,
  input  query_t      query,
  input  logic        result_valid,
  input  logic        result_ready,
  input  result_t     result,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  reg_index_t  cfg_index,
  input  coord_t      cfg_data,
  output int unsigned mismatches,
  output int unsigned outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  longint      box_center [3];
  longint      box_half [3];
  result_t     expected_results [$];
  int unsigned fail_count = 0;

  function automatic result_t predict_result(query_t q);
    longint     pa [3];
    longint     pb [3];
    longint     lo [3];
    longint     hi [3];
    longint     ov [3];
    longint     d;
    longint     cl;
    longint     sp;
    logic [69:0] mag;
    logic [69:0] dist2;
    logic [69:0] rad2;
    int         ax;
    result_t    r;
    pa[0] = q.a_x;
    pa[1] = q.a_y;
    pa[2] = q.a_z;
    pb[0] = q.b_x;
    pb[1] = q.b_y;
    pb[2] = q.b_z;
    for (int i = 0; i < 3; i++) begin
      lo[i] = box_center[i] - box_half[i];
      hi[i] = box_center[i] + box_half[i];
    end
    r = '0;
    case (q.cmd)
      CMD_BOX: begin
        r.hit = 1'b1;
        for (int i = 0; i < 3; i++) begin
          if (!(lo[i] <= pb[i] && hi[i] >= pa[i])) r.hit = 1'b0;
        end
        if (r.hit) begin
          for (int i = 0; i < 3; i++) begin
            ov[i] = (hi[i] - pa[i] < pb[i] - lo[i]) ? hi[i] - pa[i] : pb[i] - lo[i];
          end
          if (ov[0] <= ov[1] && ov[0] <= ov[2]) ax = 0;
          else if (ov[1] <= ov[2]) ax = 1;
          else ax = 2;
          sp = (2 * box_center[ax] < pa[ax] + pb[ax]) ? -ov[ax] : ov[ax];
          if (sp > longint'(PEN_MAX)) sp = PEN_MAX;
          if (sp < longint'(PEN_MIN)) sp = PEN_MIN;
          case (ax)
            0: r.pen_x = coord_t'(sp);
            1: r.pen_y = coord_t'(sp);
            default: r.pen_z = coord_t'(sp);
          endcase
        end
      end
      CMD_SPHERE: begin
        dist2 = '0;
        for (int i = 0; i < 3; i++) begin
          cl = (pa[i] < lo[i]) ? lo[i] : ((pa[i] > hi[i]) ? hi[i] : pa[i]);
          d = pa[i] - cl;
          mag = (d < 0) ? -d : d;
          dist2 = dist2 + mag * mag;
        end
        rad2 = q.radius;
        rad2 = rad2 * rad2;
        r.hit = (dist2 <= rad2);
      end
      CMD_POINT: begin
        r.hit = 1'b1;
        for (int i = 0; i < 3; i++) begin
          if (!(pa[i] >= lo[i] && pa[i] <= hi[i])) r.hit = 1'b0;
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic report_field(string field, coord_t want, coord_t got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        box_center[i] = 0;
        box_half[i]   = HALF_RESET;
      end
      expected_results.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result transaction with nothing expected, got hit=%0b pen=(%0d,%0d,%0d)",
                   $time, result.hit, result.pen_x, result.pen_y, result.pen_z);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (result.hit !== want.hit) begin
            report_field("hit", coord_t'(want.hit), coord_t'(result.hit));
          end
          if (result.pen_x !== want.pen_x) report_field("pen_x", want.pen_x, result.pen_x);
          if (result.pen_y !== want.pen_y) report_field("pen_y", want.pen_y, result.pen_y);
          if (result.pen_z !== want.pen_z) report_field("pen_z", want.pen_z, result.pen_z);
        end
      end
      if (query_valid && query_ready) expected_results.push_back(predict_result(query));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CENTER_X: box_center[0] = cfg_data;
          REG_CENTER_Y: box_center[1] = cfg_data;
          REG_CENTER_Z: box_center[2] = cfg_data;
          REG_HALF_X:   box_half[0] = cfg_data[HalfWidth-1:0];
          REG_HALF_Y:   box_half[1] = cfg_data[HalfWidth-1:0];
          REG_HALF_Z:   box_half[2] = cfg_data[HalfWidth-1:0];
          default: ;
        endcase
      end
    end
    mismatches  <= fail_count;
    outstanding <= expected_results.size();
  end

endmodule

/* tb/sv/tb_aabb_collision_tester.sv */
// Testbench top for the box collision tester: stimulus, flow control and verdict.
module tb_aabb_collision_tester;
  import aabbct_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam cmd_t       CMD_UNUSED     = 2'd3;
  localparam reg_index_t REG_SPARE_A    = 3'd6;
  localparam reg_index_t REG_SPARE_B    = 3'd7;
  localparam int         WATCHDOG_LIMIT = 4000;
  localparam int         DRAIN_CYCLES   = 12;
  localparam int         HOLD_CYCLES    = 400;
  localparam int         PHASE_ITEMS    = 160;
  localparam coord_t     Q_ONE          = 32'sh0001_0000;
  localparam coord_t     Q_HALF         = 32'sh0000_8000;
  localparam coord_t     Q_QUARTER      = 32'sh0000_4000;
  localparam ucoord_t    R_MAX          = 31'h7FFF_FFFF;

  logic        clk;
  logic        rst;
  logic        query_valid;
  logic        query_ready;
  query_t      query;
  logic        result_valid;
  logic        result_ready;
  result_t     result;
  logic        cfg_valid;
  logic        cfg_ready;
  reg_index_t  cfg_index;
  coord_t      cfg_data;
  int unsigned mismatches;
  int unsigned outstanding;

  longint stim_center [3] = '{0, 0, 0};
  longint stim_half [3]   = '{32768, 32768, 32768};
  int     hold_requested  = 0;
  int     hold_served     = 0;
  int     stall_cycles;

  aabb_collision_tester i_dut (
    .clk          (clk),
    .rst          (rst),
    .query_valid  (query_valid),
    .query_ready  (query_ready),
    .query        (query),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  aabb_collision_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .query_valid  (query_valid),
    .query_ready  (query_ready),
    .query        (query),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic query_t mk_query(cmd_t c, coord_t ax, coord_t ay, coord_t az,
                                      coord_t bx, coord_t by, coord_t bz, ucoord_t r);
    query_t q;
    q.cmd    = c;
    q.a_x    = ax;
    q.a_y    = ay;
    q.a_z    = az;
    q.b_x    = bx;
    q.b_y    = by;
    q.b_z    = bz;
    q.radius = r;
    return q;
  endfunction

  function automatic longint unsigned rand_below(longint unsigned n);
    return {$urandom, $urandom} % n;
  endfunction

  function automatic coord_t clamp_coord(longint v);
    if (v > longint'(PEN_MAX)) return PEN_MAX;
    if (v < longint'(PEN_MIN)) return PEN_MIN;
    return coord_t'(v);
  endfunction

  function automatic coord_t near_coord(int ax);
    longint span;
    case ($urandom_range(0, 7))
      0, 1: return coord_t'($urandom);
      2: return clamp_coord(stim_center[ax] + ($urandom_range(0, 1) ? stim_half[ax] :
                            -stim_half[ax]) + longint'($urandom_range(0, 2)) - 1);
      default: begin
        span = stim_half[ax] * $urandom_range(1, 3) + $urandom_range(0, 64);
        return clamp_coord(stim_center[ax] + longint'(rand_below(2 * span + 1)) - span);
      end
    endcase
  endfunction

  function automatic query_t random_query();
    query_t            q;
    coord_t            av [3];
    coord_t            bv [3];
    longint unsigned   rr;
    int                pick;
    logic [255:0]      raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    q = raw[$bits(query_t)-1:0];
    pick = $urandom_range(0, 19);
    for (int i = 0; i < 3; i++) begin
      av[i] = near_coord(i);
      if ($urandom_range(0, 9) == 0) bv[i] = near_coord(i);
      else bv[i] = clamp_coord(av[i] +
                               longint'(rand_below(stim_half[i] * $urandom_range(0, 4) + 256)));
    end
    q.a_x = av[0];
    q.a_y = av[1];
    q.a_z = av[2];
    if (pick < 9) begin
      q.cmd = CMD_BOX;
      q.b_x = bv[0];
      q.b_y = bv[1];
      q.b_z = bv[2];
    end else if (pick < 14) begin
      q.cmd = CMD_SPHERE;
      if ($urandom_range(0, 3) != 0) begin
        rr = rand_below(stim_half[0] + stim_half[1] + stim_half[2] + 65536);
        q.radius = (rr > longint'(PEN_MAX)) ? R_MAX : ucoord_t'(rr);
      end
    end else if (pick < 19) begin
      q.cmd = CMD_POINT;
    end else begin
      q.cmd = CMD_UNUSED;
    end
    return q;
  endfunction

  task automatic send_query(query_t q);
    @(negedge clk);
    query_valid <= 1'b1;
    query       <= q;
    do @(posedge clk); while (!query_ready);
  endtask

  task automatic idle_query(int n);
    @(negedge clk);
    query_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic run_random(int n);
    int burst;
    burst = 0;
    for (int k = 0; k < n; k++) begin
      if (burst == 0) begin
        if ($urandom_range(0, 3) != 0) idle_query($urandom_range(1, 20));
        burst = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 30);
      end
      send_query(random_query());
      burst--;
    end
    @(negedge clk);
    query_valid <= 1'b0;
  endtask

  task automatic write_reg(reg_index_t idx, coord_t data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_box(int phase);
    coord_t vals [6];
    for (int i = 0; i < 6; i++) begin
      case (phase)
        1: vals[i] = (i < 3) ? coord_t'($urandom_range(0, 2**21) - 2**20) :
                               coord_t'($urandom_range(0, 2**18));
        2: vals[i] = (i < 3) ? PEN_MAX : 32'hFFFF_FFFF;
        3: vals[i] = PEN_MIN;
        4: vals[i] = $urandom;
        default: begin
          case ($urandom_range(0, 3))
            0: vals[i] = PEN_MAX;
            1: vals[i] = PEN_MIN;
            2: vals[i] = coord_t'($urandom_range(0, 2**17));
            default: vals[i] = $urandom;
          endcase
        end
      endcase
    end
    write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_CENTER_X, vals[0]);
    write_reg(REG_CENTER_Y, vals[1]);
    write_reg(REG_CENTER_Z, vals[2]);
    write_reg(REG_HALF_X, vals[3]);
    write_reg(REG_HALF_Y, vals[4]);
    write_reg(REG_HALF_Z, vals[5]);
    write_reg(REG_SPARE_B, $urandom);
    @(negedge clk);
    cfg_valid <= 1'b0;
    for (int i = 0; i < 3; i++) begin
      stim_center[i] = vals[i];
      stim_half[i]   = vals[i + 3][HalfWidth-1:0];
    end
  endtask

  task automatic drain();
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int mode;
    int seg;
    result_ready = 1'b0;
    forever begin
      if (hold_served != hold_requested) begin
        hold_served++;
        repeat (HOLD_CYCLES) @(negedge clk) result_ready <= 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        seg  = $urandom_range(10, 120);
        repeat (seg) begin
          @(negedge clk);
          case (mode)
            0: result_ready <= 1'b1;
            1: result_ready <= $urandom_range(0, 1);
            2: result_ready <= ($urandom_range(0, 7) != 0);
            default: result_ready <= ($urandom_range(0, 5) == 0);
          endcase
        end
      end
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((query_valid && query_ready) || (result_valid && result_ready) ||
          (cfg_valid && cfg_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst         = 1'b1;
    query_valid = 1'b0;
    query       = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_query(mk_query(CMD_BOX, 0, 0, 0, 0, 0, 0, 0));
    send_query(mk_query(CMD_BOX, -Q_QUARTER, -Q_QUARTER, -Q_QUARTER,
                        Q_QUARTER, Q_QUARTER, Q_QUARTER, 0));
    send_query(mk_query(CMD_BOX, -Q_QUARTER, Q_QUARTER, Q_QUARTER,
                        Q_QUARTER, Q_ONE, Q_ONE, 0));
    send_query(mk_query(CMD_BOX, -Q_ONE, -Q_ONE, Q_QUARTER, Q_ONE, Q_ONE, 2 * Q_ONE, 0));
    send_query(mk_query(CMD_BOX, Q_HALF, -Q_QUARTER, -Q_QUARTER,
                        Q_ONE, Q_QUARTER, Q_QUARTER, 0));
    send_query(mk_query(CMD_BOX, Q_HALF + 1, -Q_QUARTER, -Q_QUARTER,
                        Q_ONE, Q_QUARTER, Q_QUARTER, 0));
    send_query(mk_query(CMD_BOX, Q_QUARTER, Q_QUARTER, Q_QUARTER,
                        -Q_QUARTER, -Q_QUARTER, -Q_QUARTER, 0));
    send_query(mk_query(CMD_BOX, PEN_MIN, PEN_MIN, PEN_MIN, PEN_MAX, PEN_MAX, PEN_MAX, R_MAX));
    send_query(mk_query(CMD_BOX, PEN_MIN + 2, PEN_MIN + 2, PEN_MIN + 2,
                        PEN_MAX, PEN_MAX, PEN_MAX, 0));
    send_query(mk_query(CMD_BOX, PEN_MAX, PEN_MAX, PEN_MAX, PEN_MAX, PEN_MAX, PEN_MAX, 0));
    send_query(mk_query(CMD_BOX, PEN_MIN, PEN_MIN, PEN_MIN, PEN_MIN, PEN_MIN, PEN_MIN, 0));
    send_query(mk_query(CMD_SPHERE, Q_ONE + Q_HALF, 0, 0, 0, 0, 0, ucoord_t'(Q_ONE)));
    send_query(mk_query(CMD_SPHERE, Q_ONE + Q_HALF, 0, 0, 0, 0, 0, ucoord_t'(Q_ONE - 1)));
    send_query(mk_query(CMD_SPHERE, 0, 0, 0, 0, 0, 0, 0));
    send_query(mk_query(CMD_SPHERE, Q_ONE + Q_HALF, Q_ONE + Q_HALF, Q_ONE + Q_HALF,
                        0, 0, 0, 113512));
    send_query(mk_query(CMD_SPHERE, Q_ONE + Q_HALF, Q_ONE + Q_HALF, Q_ONE + Q_HALF,
                        0, 0, 0, 113511));
    send_query(mk_query(CMD_SPHERE, PEN_MIN, PEN_MIN, PEN_MIN, 0, 0, 0, R_MAX));
    send_query(mk_query(CMD_POINT, 0, 0, 0, 0, 0, 0, 0));
    send_query(mk_query(CMD_POINT, Q_HALF, -Q_HALF, Q_HALF, 0, 0, 0, 0));
    send_query(mk_query(CMD_POINT, Q_HALF + 1, 0, 0, 0, 0, 0, 0));
    send_query(mk_query(CMD_POINT, PEN_MIN, PEN_MAX, 0, 0, 0, 0, 0));
    send_query(mk_query(CMD_UNUSED, PEN_MAX, PEN_MAX, PEN_MAX, PEN_MAX, PEN_MAX, PEN_MAX,
                        R_MAX));
    send_query(mk_query(CMD_UNUSED, 0, 0, 0, 0, 0, 0, 0));
    @(negedge clk);
    query_valid <= 1'b0;

    for (int phase = 0; phase < 6; phase++) begin
      if (phase != 0) begin
        drain();
        program_box(phase);
      end
      if (phase == 1 || phase == 4) hold_requested++;
      run_random(PHASE_ITEMS);
    end

    drain();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* aabb_collision_tester.f */
src/aabbct_pkg.sv
src/aabbct_cfg.sv
src/aabbct_sq.sv
src/aabb_collision_tester.sv
src/aabbct_chk.sv
tb/sv/aabb_collision_checker.sv
tb/sv/tb_aabb_collision_tester.sv
